### hdl/chip8_pkg.sv
// Shared types, codes and constants for the CHIP-8 instruction execute block.
`timescale 1ns / 1ps
package chip8_pkg;

  localparam int MemBytesDef     = 4096;
  localparam int ScreenWidthDef  = 64;
  localparam int ScreenHeightDef = 32;
  localparam int StackLimitDef   = 15;

  localparam logic [15:0] PC_START     = 16'h0200;
  localparam logic [3:0]  REG_VF       = 4'hF;
  localparam logic [7:0]  BCD_HUNDREDS = 8'd100;
  localparam logic [7:0]  BCD_TENS     = 8'd10;
  localparam logic [2:0]  FONT_STRIDE  = 3'd5;

  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SEI   = 4'h3;
  localparam logic [3:0] GRP_SNEI  = 4'h4;
  localparam logic [3:0] GRP_SER   = 4'h5;
  localparam logic [3:0] GRP_LDI   = 4'h6;
  localparam logic [3:0] GRP_ADDI  = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNER  = 4'h9;
  localparam logic [3:0] GRP_LDIDX = 4'hA;
  localparam logic [3:0] GRP_JPV0  = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRW   = 4'hD;
  localparam logic [3:0] GRP_KEY   = 4'hE;
  localparam logic [3:0] GRP_MISC  = 4'hF;

  localparam logic [3:0] SYS_CLS = 4'h0;
  localparam logic [3:0] SYS_RET = 4'hE;
  localparam logic [3:0] SYS_NOP = 4'hF;

  localparam logic [3:0] A8_MOV  = 4'h0;
  localparam logic [3:0] A8_OR   = 4'h1;
  localparam logic [3:0] A8_AND  = 4'h2;
  localparam logic [3:0] A8_XOR  = 4'h3;
  localparam logic [3:0] A8_ADD  = 4'h4;
  localparam logic [3:0] A8_SUB  = 4'h5;
  localparam logic [3:0] A8_SHR  = 4'h6;
  localparam logic [3:0] A8_SUBN = 4'h7;
  localparam logic [3:0] A8_SHL  = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] FX_GETDT = 8'h07;
  localparam logic [7:0] FX_WKEY  = 8'h0A;
  localparam logic [7:0] FX_SETDT = 8'h15;
  localparam logic [7:0] FX_SETST = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  typedef enum logic [1:0] {FN_EXEC, FN_WRITE, FN_READ, FN_PIXEL} func_e;
  typedef enum logic [1:0] {ST_OK, ST_UNKNOWN, ST_OVERFLOW, ST_UNDERFLOW} status_e;
  typedef enum logic [1:0] {IK_BCD, IK_STORE, IK_LOAD, IK_DRAW} ikind_e;

  typedef enum logic [3:0] {
    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MEMW, S_MEMR, S_MEMRW, S_PDIV, S_PRQ, S_PRW, S_RDX, S_RDY, S_DEC,
    S_WRX, S_IMOD, S_BCDH, S_BCDT, S_BCDO, S_STORE, S_LDRQ, S_LDWR, S_DMODX,
    S_DMODY, S_DRQ, S_DRW, S_DONE
  } state_e;

endpackage

### hdl/chip8_alu.sv
// Shared 8-bit arithmetic, logic and shift unit with flag output.
`timescale 1ns / 1ps
module chip8_alu (
  input  chip8_pkg::alu_req_t req_i,
  output logic [7:0]          res_o,
  output logic                flag_o
);
  import chip8_pkg::*;

  logic [8:0] sum;
  logic [8:0] dif;
  logic [8:0] rdif;

  assign sum  = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign dif  = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rdif = {1'b0, req_i.b} - {1'b0, req_i.a};

  always_comb begin
    res_o  = req_i.b;
    flag_o = 1'b0;
    unique case (req_i.op)
      ALU_MOV: res_o = req_i.b;
      ALU_OR:  res_o = req_i.a | req_i.b;
      ALU_AND: res_o = req_i.a & req_i.b;
      ALU_XOR: res_o = req_i.a ^ req_i.b;
      ALU_ADD: begin
        res_o  = sum[7:0];
        flag_o = sum[8];
      end
      ALU_SUB: begin
        res_o  = dif[7:0];
        flag_o = ~dif[8];
      end
      ALU_SHR: begin
        res_o  = {1'b0, req_i.a[7:1]};
        flag_o = req_i.a[0];
      end
      ALU_SUBN: begin
        res_o  = rdif[7:0];
        flag_o = ~rdif[8];
      end
      ALU_SHL: begin
        res_o  = {req_i.a[6:0], 1'b0};
        flag_o = req_i.a[7];
      end
      default: begin
        res_o  = req_i.b;
        flag_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/chip8_instruction_execute.sv
// Top level: CHIP-8 instruction sequencer with register file, memory and display.
//
//  Channel   Dir  Handshake                    Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser func, tdata operands
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata status, pc, draw, read data
//
// Plain instructions read Vx and Vy, then decode; ALU ops then write Vx. Index-based
// instructions first reduce I modulo MEM_BYTES (one subtract per cycle); then BCD
// subtracts out hundreds, then tens, and store and load step through the registers.
// Draw adds the coordinate wrap loops and a read and a write per sprite row; a pixel
// read walks the address down one screen row per cycle. Row valid bits clear the
// display at reset and on clear-screen. A result waits in the output register.
`timescale 1ns / 1ps
module chip8_instruction_execute #(
  parameter int MEM_BYTES     = chip8_pkg::MemBytesDef,
  parameter int SCREEN_WIDTH  = chip8_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = chip8_pkg::ScreenHeightDef,
  parameter int STACK_LIMIT   = chip8_pkg::StackLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[15:0], key_mask[31:16], random_byte[39:32], address[51:40],
  // data_byte[59:52], zero fill [63:60]
  input  logic [63:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], program_counter[17:2], draw_flag[18], read_data[26:19],
  // zero fill [31:27]
  output logic [31:0] m_axis_tdata
);
  import chip8_pkg::*;

  localparam int AW     = $clog2(MEM_BYTES);
  localparam int XW     = $clog2(SCREEN_WIDTH);
  localparam int YW     = $clog2(SCREEN_HEIGHT);
  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic [16:0] MEM_L = 17'(MEM_BYTES);
  localparam logic [8:0]  W_L   = 9'(SCREEN_WIDTH);
  localparam logic [8:0]  H_L   = 9'(SCREEN_HEIGHT);

  state_e state_q, state_d;

  logic [7:0]  v_q [16];
  logic [15:0] stk_q [16];
  logic [7:0]  mem [MEM_BYTES];
  logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_vld_q;

  logic [15:0] pc_q, pc_d, i_q, i_d;
  logic [4:0]  sp_q, sp_d;
  logic [7:0]  dt_q, dt_d, snd_q, snd_d;

  logic [15:0] op_q, keys_q;
  logic [7:0]  rnd_q, data_q;
  logic [11:0] addr_q;

  logic [7:0]  vx_q, vx_d, vy_q, vy_d;
  logic [16:0] base_q, base_d;
  logic [7:0]  pxm_q, pxm_d, pym_q, pym_d;
  logic [3:0]  cnt_q, cnt_d, dig_q, dig_d;
  logic [11:0] tmp_q, tmp_d;
  logic [YW-1:0] row_q, row_d;
  logic [7:0]  bcdv_q, bcdv_d;
  alu_op_e     alu_op_q, alu_op_d;
  ikind_e      kind_q, kind_d;
  status_e     res_st_q, res_st_d;
  logic        res_draw_q, res_draw_d;
  logic [7:0]  res_rd_q, res_rd_d;

  logic        m_valid_q;
  status_e     out_st_q;
  logic [15:0] out_pc_q;
  logic        out_draw_q;
  logic [7:0]  out_rd_q;

  logic        in_acc, out_ld;
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [7:0]  rf_wdata, rf_rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_q;
  logic        frame_we, frame_clr;
  logic [YW-1:0] frame_raddr, py_cur;
  logic [SCREEN_WIDTH-1:0] frame_q, frame_old, mask;
  logic        stk_we;
  logic [15:0] stk_rdata;
  logic [8:0]  py_sum;
  logic [3:0]  key_hi;
  alu_req_t    alu_req;
  logic [7:0]  alu_res;
  logic        alu_flag;

  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;

  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[11:0];

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign rf_rdata  = v_q[rf_raddr];
  assign stk_rdata = stk_q[sp_q[3:0] - 4'd1];
  assign py_sum    = {1'b0, pym_q} + 9'(cnt_q);
  assign frame_old = row_vld_q[py_cur] ? frame_q : '0;

  always_comb begin
    logic [8:0] s;
    s = (py_sum >= H_L) ? py_sum - H_L : py_sum;
    py_cur = s[YW-1:0];
  end

  always_comb begin
    logic [8:0] pos;
    mask = '0;
    for (int c = 0; c < 8; c++) begin
      pos = {1'b0, pxm_q} + 9'(c);
      if (pos >= W_L) pos = pos - W_L;
      if (mem_q[7-c]) mask[pos[XW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    key_hi = '0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) key_hi = 4'(k);
    end
  end

  function automatic logic [AW-1:0] maddr(input logic [16:0] base, input logic [3:0] off);
    logic [16:0] s;
    s = base + 17'(off);
    if (s >= MEM_L) s = s - MEM_L;
    return s[AW-1:0];
  endfunction

  chip8_alu u_alu (
    .req_i  (alu_req),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    i_d        = i_q;
    sp_d       = sp_q;
    dt_d       = dt_q;
    snd_d      = snd_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    base_d     = base_q;
    pxm_d      = pxm_q;
    pym_d      = pym_q;
    cnt_d      = cnt_q;
    dig_d      = dig_q;
    tmp_d      = tmp_q;
    row_d      = row_q;
    bcdv_d     = bcdv_q;
    alu_op_d   = alu_op_q;
    kind_d     = kind_q;
    res_st_d   = res_st_q;
    res_draw_d = res_draw_q;
    res_rd_d   = res_rd_q;
    s_axis_tready = 1'b0;
    out_ld      = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = x;
    rf_wdata    = alu_res;
    rf_raddr    = x;
    mem_we      = 1'b0;
    mem_waddr   = maddr(base_q, 4'd0);
    mem_wdata   = data_q;
    mem_raddr   = maddr(base_q, cnt_q);
    frame_we    = 1'b0;
    frame_clr   = 1'b0;
    frame_raddr = py_cur;
    stk_we      = 1'b0;
    alu_req.op  = ALU_MOV;
    alu_req.a   = vx_q;
    alu_req.b   = vy_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          res_st_d   = ST_OK;
          res_draw_d = 1'b0;
          res_rd_d   = '0;
          tmp_d      = s_axis_tdata[51:40];
          row_d      = '0;
          unique case (func_e'(s_axis_tuser))
            FN_EXEC:  state_d = S_RDX;
            FN_WRITE: state_d = S_MEMW;
            FN_READ:  state_d = S_MEMR;
            FN_PIXEL: state_d = S_PDIV;
          endcase
        end
      end
      S_MEMW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(addr_q);
        state_d   = S_DONE;
      end
      S_MEMR: begin
        mem_raddr = AW'(addr_q);
        state_d   = S_MEMRW;
      end
      S_MEMRW: begin
        res_rd_d = mem_q;
        state_d  = S_DONE;
      end
      S_PDIV: begin
        if (17'(addr_q) >= 17'(PIXELS)) begin
          state_d = S_DONE;
        end else if (9'(tmp_q) >= W_L && tmp_q[11:9] == 3'd0 || tmp_q[11:9] != 3'd0) begin
          tmp_d = tmp_q - 12'(SCREEN_WIDTH);
          row_d = row_q + 1'b1;
        end else begin
          state_d = S_PRQ;
        end
      end
      S_PRQ: begin
        frame_raddr = row_q;
        state_d     = S_PRW;
      end
      S_PRW: begin
        res_rd_d = {7'd0, row_vld_q[row_q] & frame_q[tmp_q[XW-1:0]]};
        state_d  = S_DONE;
      end
      S_RDX: begin
        rf_raddr = x;
        vx_d     = rf_rdata;
        state_d  = S_RDY;
      end
      S_RDY: begin
        rf_raddr = y;
        vy_d     = rf_rdata;
        state_d  = S_DEC;
      end
      S_DEC: begin
        state_d = S_DONE;
        base_d  = {1'b0, i_q};
        cnt_d   = '0;
        unique case (op_q[15:12])
          GRP_SYS: begin
            priority case (n)
              SYS_CLS: begin
                frame_clr  = 1'b1;
                res_draw_d = 1'b1;
                pc_d       = pc_q + 16'd2;
              end
              SYS_RET: begin
                if (sp_q == '0) begin
                  res_st_d = ST_UNDERFLOW;
                end else begin
                  sp_d = sp_q - 5'd1;
                  pc_d = stk_rdata + 16'd2;
                end
              end
              SYS_NOP: pc_d = pc_q + 16'd2;
              default: res_st_d = ST_UNKNOWN;
            endcase
          end
          GRP_JP: pc_d = {4'd0, nnn};
          GRP_CALL: begin
            if (sp_q >= 5'(STACK_LIMIT)) begin
              res_st_d = ST_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              sp_d   = sp_q + 5'd1;
              pc_d   = {4'd0, nnn};
            end
          end
          GRP_SEI:  pc_d = pc_q + ((vx_q == nn) ? 16'd4 : 16'd2);
          GRP_SNEI: pc_d = pc_q + ((vx_q != nn) ? 16'd4 : 16'd2);
          GRP_SER:  pc_d = pc_q + ((vx_q == vy_q) ? 16'd4 : 16'd2);
          GRP_SNER: pc_d = pc_q + ((vx_q != vy_q) ? 16'd4 : 16'd2);
          GRP_LDI: begin
            rf_we    = 1'b1;
            rf_wdata = nn;
            pc_d     = pc_q + 16'd2;
          end
          GRP_ADDI: begin
            alu_op_d = ALU_ADD;
            vy_d     = nn;
            state_d  = S_WRX;
          end
          GRP_ALU: begin
            state_d = S_WRX;
            priority case (n)
              A8_MOV:  alu_req.op = ALU_MOV;
              A8_OR:   alu_req.op = ALU_OR;
              A8_AND:  alu_req.op = ALU_AND;
              A8_XOR:  alu_req.op = ALU_XOR;
              A8_ADD:  alu_req.op = ALU_ADD;
              A8_SUB:  alu_req.op = ALU_SUB;
              A8_SHR:  alu_req.op = ALU_SHR;
              A8_SUBN: alu_req.op = ALU_SUBN;
              A8_SHL:  alu_req.op = ALU_SHL;
              default: begin
                res_st_d = ST_UNKNOWN;
                state_d  = S_DONE;
              end
            endcase
            alu_op_d = alu_req.op;
            if (n == A8_ADD || n == A8_SUB || n == A8_SHR || n == A8_SUBN || n == A8_SHL)
            begin
              rf_we    = 1'b1;
              rf_waddr = REG_VF;
              rf_wdata = {7'd0, alu_flag};
              // The main result sees the flag register as already updated.
              if (x == REG_VF) vx_d = {7'd0, alu_flag};
              if (y == REG_VF) vy_d = {7'd0, alu_flag};
            end
          end
          GRP_LDIDX: begin
            i_d  = {4'd0, nnn};
            pc_d = pc_q + 16'd2;
          end
          GRP_JPV0: pc_d = {4'd0, nnn} + {8'd0, v_q[0]};
          GRP_RND: begin
            rf_we    = 1'b1;
            rf_wdata = rnd_q & nn;
            pc_d     = pc_q + 16'd2;
          end
          GRP_DRW: begin
            rf_we    = 1'b1;
            rf_waddr = REG_VF;
            rf_wdata = '0;
            pxm_d    = vx_q;
            pym_d    = vy_q;
            kind_d   = IK_DRAW;
            state_d  = S_DMODX;
          end
          GRP_KEY: begin
            priority case (nn)
              KEY_SKP:  pc_d = pc_q + (keys_q[vx_q[3:0]] ? 16'd4 : 16'd2);
              KEY_SKNP: pc_d = pc_q + (keys_q[vx_q[3:0]] ? 16'd2 : 16'd4);
              default:  res_st_d = ST_UNKNOWN;
            endcase
          end
          GRP_MISC: begin
            priority case (nn)
              FX_GETDT: begin
                rf_we    = 1'b1;
                rf_wdata = dt_q;
                pc_d     = pc_q + 16'd2;
              end
              FX_WKEY: begin
                if (keys_q != '0) begin
                  rf_we    = 1'b1;
                  rf_wdata = {4'd0, key_hi};
                  pc_d     = pc_q + 16'd2;
                end
              end
              FX_SETDT: begin
                dt_d = vx_q;
                pc_d = pc_q + 16'd2;
              end
              FX_SETST: begin
                snd_d = vx_q;
                pc_d  = pc_q + 16'd2;
              end
              FX_ADDI: begin
                i_d  = i_q + {8'd0, vx_q};
                pc_d = pc_q + 16'd2;
              end
              FX_FONT: begin
                i_d  = 16'(vx_q * FONT_STRIDE);
                pc_d = pc_q + 16'd2;
              end
              FX_BCD: begin
                bcdv_d  = vx_q;
                dig_d   = '0;
                kind_d  = IK_BCD;
                state_d = S_IMOD;
              end
              FX_STORE: begin
                kind_d  = IK_STORE;
                state_d = S_IMOD;
              end
              FX_LOAD: begin
                kind_d  = IK_LOAD;
                state_d = S_IMOD;
              end
              default: res_st_d = ST_UNKNOWN;
            endcase
          end
        endcase
      end
      S_WRX: begin
        alu_req.op = alu_op_q;
        rf_we      = 1'b1;
        rf_wdata   = alu_res;
        pc_d       = pc_q + 16'd2;
        state_d    = S_DONE;
      end
      S_DMODX: begin
        if ({1'b0, pxm_q} >= W_L) pxm_d = pxm_q - 8'(SCREEN_WIDTH);
        else state_d = S_DMODY;
      end
      S_DMODY: begin
        if ({1'b0, pym_q} >= H_L) pym_d = pym_q - 8'(SCREEN_HEIGHT);
        else state_d = S_IMOD;
      end
      S_IMOD: begin
        if (base_q >= MEM_L) begin
          base_d = base_q - MEM_L;
        end else begin
          unique case (kind_q)
            IK_BCD:   state_d = S_BCDH;
            IK_STORE: state_d = S_STORE;
            IK_LOAD:  state_d = S_LDRQ;
            IK_DRAW:  state_d = S_DRQ;
          endcase
        end
      end
      S_BCDH: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = bcdv_q;
        alu_req.b  = BCD_HUNDREDS;
        if (alu_flag) begin
          bcdv_d = alu_res;
          dig_d  = dig_q + 4'd1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = maddr(base_q, 4'd0);
          mem_wdata = {4'd0, dig_q};
          dig_d     = '0;
          state_d   = S_BCDT;
        end
      end
      S_BCDT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = bcdv_q;
        alu_req.b  = BCD_TENS;
        if (alu_flag) begin
          bcdv_d = alu_res;
          dig_d  = dig_q + 4'd1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = maddr(base_q, 4'd1);
          mem_wdata = {4'd0, dig_q};
          state_d   = S_BCDO;
        end
      end
      S_BCDO: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(base_q, 4'd2);
        mem_wdata = bcdv_q;
        pc_d      = pc_q + 16'd2;
        state_d   = S_DONE;
      end
      S_STORE: begin
        rf_raddr  = cnt_q;
        mem_we    = 1'b1;
        mem_waddr = maddr(base_q, cnt_q);
        mem_wdata = rf_rdata;
        if (cnt_q == x) begin
          pc_d    = pc_q + 16'd2;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_LDRQ: begin
        mem_raddr = maddr(base_q, cnt_q);
        state_d   = S_LDWR;
      end
      S_LDWR: begin
        rf_we    = 1'b1;
        rf_waddr = cnt_q;
        rf_wdata = mem_q;
        if (cnt_q == x) begin
          pc_d    = pc_q + 16'd2;
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_LDRQ;
        end
      end
      S_DRQ: begin
        if (cnt_q == n) begin
          res_draw_d = 1'b1;
          pc_d       = pc_q + 16'd2;
          state_d    = S_DONE;
        end else begin
          mem_raddr   = maddr(base_q, cnt_q);
          frame_raddr = py_cur;
          state_d     = S_DRW;
        end
      end
      S_DRW: begin
        frame_we = 1'b1;
        if ((frame_old & mask) != '0) begin
          rf_we    = 1'b1;
          rf_waddr = REG_VF;
          rf_wdata = 8'd1;
        end
        cnt_d   = cnt_q + 4'd1;
        state_d = S_DRQ;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= PC_START;
      i_q       <= '0;
      sp_q      <= '0;
      dt_q      <= '0;
      snd_q     <= '0;
      row_vld_q <= '0;
      m_valid_q <= 1'b0;
      for (int r = 0; r < 16; r++) v_q[r] <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      i_q     <= i_d;
      sp_q    <= sp_d;
      dt_q    <= dt_d;
      snd_q   <= snd_d;
      if (rf_we) v_q[rf_waddr] <= rf_wdata;
      if (frame_clr) row_vld_q <= '0;
      else if (frame_we) row_vld_q[py_cur] <= 1'b1;
      if (out_ld) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tdata[15:0];
      keys_q <= s_axis_tdata[31:16];
      rnd_q  <= s_axis_tdata[39:32];
      addr_q <= s_axis_tdata[51:40];
      data_q <= s_axis_tdata[59:52];
    end
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    base_q     <= base_d;
    pxm_q      <= pxm_d;
    pym_q      <= pym_d;
    cnt_q      <= cnt_d;
    dig_q      <= dig_d;
    tmp_q      <= tmp_d;
    row_q      <= row_d;
    bcdv_q     <= bcdv_d;
    alu_op_q   <= alu_op_d;
    kind_q     <= kind_d;
    res_st_q   <= res_st_d;
    res_draw_q <= res_draw_d;
    res_rd_q   <= res_rd_d;
    if (out_ld) begin
      out_st_q   <= res_st_q;
      out_pc_q   <= pc_q;
      out_draw_q <= res_draw_q;
      out_rd_q   <= res_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_q[sp_q[3:0]] <= pc_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) frame_mem[py_cur] <= frame_old ^ mask;
    frame_q <= frame_mem[frame_raddr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, out_rd_q, out_draw_q, out_pc_q, out_st_q};

`ifndef ASSERT_OFF
  a_sp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= 5'(STACK_LIMIT))
    else $error("stack pointer beyond limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
    else $error("sequencer idle right after accepting a word");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_st_q == ST_OVERFLOW) |-> (sp_q >= 5'(STACK_LIMIT)))
    else $error("overflow reported with room on the stack");
`endif

endmodule

### test/chip8_instruction_execute_test.sv
// Testbench for the CHIP-8 instruction execute block: directed, stack, random and backpressure runs.
`timescale 1ns / 1ps
module chip8_instruction_execute_test;
  import chip8_pkg::*;

  typedef struct {
    func_e       fn;
    logic [15:0] op;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [11:0] addr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [15:0] pc;
    logic        draw;
    logic [7:0]  rd;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [7:0]  vreg [16];
  logic [15:0] idx_reg;
  logic [15:0] pc_reg;
  int          sp;
  logic [15:0] ret_stack [16];
  logic [7:0]  delay_t;
  logic [7:0]  sound_t;
  logic [7:0]  mem [MemBytesDef];
  bit          mem_known [MemBytesDef];
  bit          pixels [ScreenWidthDef * ScreenHeightDef];

  outcome_t pending_results [$];
  int  error_count = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  int  hold_request = 0;

  chip8_instruction_execute dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("chip8_instruction_execute regression: fail");
    $finish;
  end

  function automatic int mem_at(int off);
    return (int'(idx_reg) + off) % MemBytesDef;
  endfunction

  function automatic cmd_t mk(func_e fn, logic [15:0] op, logic [15:0] keys = 16'h0,
                              logic [7:0] rnd = 8'h0, logic [11:0] addr = 12'h0,
                              logic [7:0] data = 8'h0);
    cmd_t c;
    c.fn = fn; c.op = op; c.keys = keys; c.rnd = rnd; c.addr = addr; c.data = data;
    return c;
  endfunction

  function automatic outcome_t predict_cpu(cmd_t c);
    outcome_t o;
    logic [3:0] x, y, n;
    logic [7:0] nn, bits;
    logic [11:0] nnn;
    logic [7:0] px0, py0;
    logic [8:0] sum;
    int i, r, px, py;
    bit bad;
    x = c.op[11:8]; y = c.op[7:4]; n = c.op[3:0]; nn = c.op[7:0]; nnn = c.op[11:0];
    o.status = ST_OK; o.draw = 1'b0; o.rd = 8'h0; bad = 1'b0;
    case (c.fn)
      FN_EXEC: begin
        case (c.op[15:12])
          GRP_SYS: begin
            if (n == SYS_CLS) begin
              foreach (pixels[k]) pixels[k] = 1'b0;
              o.draw = 1'b1;
              pc_reg = pc_reg + 16'd2;
            end else if (n == SYS_RET) begin
              if (sp == 0) begin
                o.status = ST_UNDERFLOW;
              end else begin
                sp--;
                pc_reg = ret_stack[sp] + 16'd2;
              end
            end else if (n == SYS_NOP) begin
              pc_reg = pc_reg + 16'd2;
            end else begin
              o.status = ST_UNKNOWN;
            end
          end
          GRP_JP: pc_reg = {4'h0, nnn};
          GRP_CALL: begin
            if (sp >= StackLimitDef) begin
              o.status = ST_OVERFLOW;
            end else begin
              ret_stack[sp] = pc_reg;
              sp++;
              pc_reg = {4'h0, nnn};
            end
          end
          GRP_SEI: pc_reg = pc_reg + ((vreg[x] == nn) ? 16'd4 : 16'd2);
          GRP_SNEI: pc_reg = pc_reg + ((vreg[x] != nn) ? 16'd4 : 16'd2);
          GRP_SER: pc_reg = pc_reg + ((vreg[x] == vreg[y]) ? 16'd4 : 16'd2);
          GRP_LDI: begin
            vreg[x] = nn;
            pc_reg = pc_reg + 16'd2;
          end
          GRP_ADDI: begin
            vreg[x] = vreg[x] + nn;
            pc_reg = pc_reg + 16'd2;
          end
          GRP_ALU: begin
            case (n)
              A8_MOV: vreg[x] = vreg[y];
              A8_OR:  vreg[x] = vreg[x] | vreg[y];
              A8_AND: vreg[x] = vreg[x] & vreg[y];
              A8_XOR: vreg[x] = vreg[x] ^ vreg[y];
              A8_ADD: begin
                sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                vreg[REG_VF] = {7'h0, sum[8]};
                vreg[x] = vreg[x] + vreg[y];
              end
              A8_SUB: begin
                vreg[REG_VF] = (vreg[x] < vreg[y]) ? 8'h0 : 8'h1;
                vreg[x] = vreg[x] - vreg[y];
              end
              A8_SHR: begin
                vreg[REG_VF] = {7'h0, vreg[x][0]};
                vreg[x] = vreg[x] >> 1;
              end
              A8_SUBN: begin
                vreg[REG_VF] = (vreg[x] > vreg[y]) ? 8'h0 : 8'h1;
                vreg[x] = vreg[y] - vreg[x];
              end
              A8_SHL: begin
                vreg[REG_VF] = {7'h0, vreg[x][7]};
                vreg[x] = vreg[x] << 1;
              end
              default: bad = 1'b1;
            endcase
            if (bad) o.status = ST_UNKNOWN;
            else pc_reg = pc_reg + 16'd2;
          end
          GRP_SNER: pc_reg = pc_reg + ((vreg[x] != vreg[y]) ? 16'd4 : 16'd2);
          GRP_LDIDX: begin
            idx_reg = {4'h0, nnn};
            pc_reg = pc_reg + 16'd2;
          end
          GRP_JPV0: pc_reg = {4'h0, nnn} + {8'h0, vreg[0]};
          GRP_RND: begin
            vreg[x] = c.rnd & nn;
            pc_reg = pc_reg + 16'd2;
          end
          GRP_DRW: begin
            px0 = vreg[x]; py0 = vreg[y];
            vreg[REG_VF] = 8'h0;
            for (r = 0; r < n; r++) begin
              bits = mem[mem_at(r)];
              py = (int'(py0) + r) % ScreenHeightDef;
              for (i = 0; i < 8; i++) begin
                if (bits[7 - i]) begin
                  px = (int'(px0) + i) % ScreenWidthDef;
                  if (pixels[py * ScreenWidthDef + px]) vreg[REG_VF] = 8'h1;
                  pixels[py * ScreenWidthDef + px] ^= 1'b1;
                end
              end
            end
            o.draw = 1'b1;
            pc_reg = pc_reg + 16'd2;
          end
          GRP_KEY: begin
            if (nn == KEY_SKP) pc_reg = pc_reg + (c.keys[vreg[x][3:0]] ? 16'd4 : 16'd2);
            else if (nn == KEY_SKNP) pc_reg = pc_reg + (c.keys[vreg[x][3:0]] ? 16'd2 : 16'd4);
            else o.status = ST_UNKNOWN;
          end
          default: begin
            case (nn)
              FX_GETDT: vreg[x] = delay_t;
              FX_WKEY: begin
                for (i = 15; i >= 0; i--) begin
                  if (c.keys[i] && !bad) begin
                    vreg[x] = 8'(i);
                    bad = 1'b1;
                  end
                end
              end
              FX_SETDT: delay_t = vreg[x];
              FX_SETST: sound_t = vreg[x];
              FX_ADDI:  idx_reg = idx_reg + {8'h0, vreg[x]};
              FX_FONT:  idx_reg = 16'(vreg[x] * 5);
              FX_BCD: begin
                mem[mem_at(0)] = vreg[x] / 100;
                mem[mem_at(1)] = (vreg[x] % 100) / 10;
                mem[mem_at(2)] = vreg[x] % 10;
                for (i = 0; i < 3; i++) mem_known[mem_at(i)] = 1'b1;
              end
              FX_STORE: begin
                for (i = 0; i <= x; i++) begin
                  mem[mem_at(i)] = vreg[i];
                  mem_known[mem_at(i)] = 1'b1;
                end
              end
              FX_LOAD: for (i = 0; i <= x; i++) vreg[i] = mem[mem_at(i)];
              default: o.status = ST_UNKNOWN;
            endcase
            if (nn == FX_WKEY) begin
              if (bad) pc_reg = pc_reg + 16'd2;
            end else if (o.status == ST_OK) begin
              pc_reg = pc_reg + 16'd2;
            end
          end
        endcase
      end
      FN_WRITE: begin
        mem[c.addr] = c.data;
        mem_known[c.addr] = 1'b1;
      end
      FN_READ: o.rd = mem[c.addr];
      default: o.rd = (c.addr < ScreenWidthDef * ScreenHeightDef) ? {7'h0, pixels[c.addr]} : 8'h0;
    endcase
    o.pc = pc_reg;
    return o;
  endfunction

  task automatic push_word(cmd_t c);
    s_axis_tuser <= c.fn;
    s_axis_tdata <= {4'h0, c.data, c.addr, c.rnd, c.keys, c.op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_cpu(c));
    words_sent++;
    if (gaps_on && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Bytes that an item reads get a random value written first, unless already written.
  task automatic issue(cmd_t c);
    int need [$];
    int i;
    if (c.fn == FN_READ) need.push_back(c.addr);
    if (c.fn == FN_EXEC && c.op[15:12] == GRP_DRW)
      for (i = 0; i < c.op[3:0]; i++) need.push_back(mem_at(i));
    if (c.fn == FN_EXEC && c.op[15:12] == GRP_MISC && c.op[7:0] == FX_LOAD)
      for (i = 0; i <= c.op[11:8]; i++) need.push_back(mem_at(i));
    foreach (need[k]) begin
      if (!mem_known[need[k]])
        push_word(mk(FN_WRITE, 16'($urandom), 16'($urandom), 8'($urandom),
                     12'(need[k]), 8'($urandom)));
    end
    push_word(c);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    outcome_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          e = pending_results.pop_front();
          if (m_axis_tdata[1:0] != e.status || m_axis_tdata[17:2] != e.pc ||
              m_axis_tdata[18] != e.draw || m_axis_tdata[26:19] != e.rd) begin
            $display("%0t: expected status %0d pc %h draw %0d data %h, got %0d %h %0d %h",
                     $time, e.status, e.pc, e.draw, e.rd, m_axis_tdata[1:0],
                     m_axis_tdata[17:2], m_axis_tdata[18], m_axis_tdata[26:19]);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        m_axis_tready <= 1'b0;
        hold_request--;
      end else begin
        m_axis_tready <= !(stalls_on && $urandom_range(99) < 10);
      end
    end
  end

  function automatic cmd_t random_cmd;
    cmd_t c;
    logic [3:0] grp;
    int pick;
    logic [3:0] sys_low [4];
    logic [7:0] f_low [10];
    sys_low = '{SYS_CLS, SYS_RET, SYS_NOP, 4'h5};
    f_low = '{FX_GETDT, FX_WKEY, FX_SETDT, FX_SETST, FX_ADDI, FX_FONT, FX_BCD,
              FX_STORE, FX_LOAD, 8'h42};
    c = mk(FN_EXEC, 16'($urandom), ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom),
           8'($urandom), 12'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 8) c.fn = FN_WRITE;
    else if (pick < 15) c.fn = FN_READ;
    else if (pick < 21) begin
      c.fn = FN_PIXEL;
      if ($urandom_range(3) != 0) c.addr[11] = 1'b0;
    end
    grp = c.op[15:12];
    if (grp == GRP_SYS && $urandom_range(7) != 0) c.op[3:0] = sys_low[$urandom_range(3)];
    if (grp == GRP_ALU && $urandom_range(7) != 0) c.op[3] = 1'b0;
    if (grp == GRP_KEY && $urandom_range(7) != 0) c.op[7:0] = $urandom_range(1) ? KEY_SKP : KEY_SKNP;
    if (grp == GRP_MISC && $urandom_range(9) != 0) c.op[7:0] = f_low[$urandom_range(9)];
    return c;
  endfunction

  task automatic test_directed;
    push_word(mk(FN_PIXEL, 16'h0, 16'h0, 8'h0, 12'h000));
    issue(mk(FN_EXEC, {GRP_SYS, 8'h0E, SYS_CLS}));
    issue(mk(FN_EXEC, {GRP_SYS, 8'h0F, SYS_NOP}));
    issue(mk(FN_EXEC, 16'h0123));
    issue(mk(FN_EXEC, {GRP_SYS, 8'h0E, SYS_RET}));
    issue(mk(FN_EXEC, 16'h6AFF));
    issue(mk(FN_EXEC, 16'h7A01));
    issue(mk(FN_EXEC, 16'h6BFF));
    issue(mk(FN_EXEC, 16'h6FFF));
    issue(mk(FN_EXEC, {GRP_ALU, 8'hFB, A8_ADD}));
    issue(mk(FN_EXEC, {GRP_ALU, 8'hAB, A8_SUB}));
    issue(mk(FN_EXEC, {GRP_ALU, 8'hB0, A8_SHR}));
    issue(mk(FN_EXEC, {GRP_ALU, 8'hAB, A8_SUBN}));
    issue(mk(FN_EXEC, {GRP_ALU, 8'hBA, A8_SHL}));
    issue(mk(FN_EXEC, 16'h8AB8));
    issue(mk(FN_EXEC, {GRP_MISC, 4'hB, FX_FONT}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'hB, FX_BCD}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'hF, FX_STORE}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h5, FX_LOAD}));
    push_word(mk(FN_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF, 8'hFF));
    issue(mk(FN_READ, 16'h0, 16'h0, 8'h0, 12'hFFF));
    issue(mk(FN_EXEC, 16'hD01F));
    issue(mk(FN_EXEC, 16'hD01F));
    issue(mk(FN_EXEC, 16'hDEEF));
    push_word(mk(FN_PIXEL, 16'h0, 16'h0, 8'h0, 12'd2047));
    push_word(mk(FN_PIXEL, 16'h0, 16'h0, 8'h0, 12'hFFF));
    issue(mk(FN_EXEC, {GRP_KEY, 4'h1, KEY_SKP}, 16'hFFFF));
    issue(mk(FN_EXEC, {GRP_KEY, 4'h1, KEY_SKNP}, 16'h0000));
    issue(mk(FN_EXEC, 16'hE1FF));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h2, FX_WKEY}, 16'h0000));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h2, FX_WKEY}, 16'h8001));
    issue(mk(FN_EXEC, 16'hC3FF, 16'h0, 8'hAA));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h7, FX_SETDT}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h7, FX_SETST}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h1, FX_GETDT}));
    issue(mk(FN_EXEC, {GRP_MISC, 4'h0, FX_ADDI}));
    issue(mk(FN_EXEC, 16'hF199));
    issue(mk(FN_EXEC, 16'hBFFF));
    issue(mk(FN_EXEC, 16'h1FFF));
    issue(mk(FN_EXEC, 16'h2ABC));
    issue(mk(FN_EXEC, {GRP_SYS, 8'h0E, SYS_RET}));
    drain();
  endtask

  task automatic test_stack;
    int i;
    for (i = 0; i <= StackLimitDef; i++) issue(mk(FN_EXEC, {GRP_CALL, 12'($urandom)}));
    for (i = 0; i <= StackLimitDef; i++) issue(mk(FN_EXEC, {GRP_SYS, 8'h0E, SYS_RET}));
    drain();
  endtask

  task automatic test_random(int count);
    int i;
    for (i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 2);
      stalls_on = gaps_on;
      issue(random_cmd());
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    drain();
  endtask

  task automatic test_backpressure;
    int i;
    hold_request = 400;
    gaps_on = 1'b0;
    for (i = 0; i < 40; i++) issue(random_cmd());
    gaps_on = 1'b1;
    drain();
    for (i = 0; i < 20; i++) issue(random_cmd());
    drain();
  endtask

  initial begin
    foreach (vreg[k]) vreg[k] = 8'h0;
    foreach (ret_stack[k]) ret_stack[k] = 16'h0;
    foreach (mem[k]) begin
      mem[k] = 8'h0;
      mem_known[k] = 1'b0;
    end
    foreach (pixels[k]) pixels[k] = 1'b0;
    idx_reg = 16'h0; pc_reg = PC_START; sp = 0; delay_t = 8'h0; sound_t = 8'h0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stack();
    test_random(1150);
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered every opcode group, memory and pixel access, stack limits and stalls:");
    $display("%0d words sent, %0d results checked, %0d mismatches.",
             words_sent, words_checked, error_count + pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("chip8_instruction_execute regression: pass");
    end else begin
      $display("chip8_instruction_execute regression: fail");
    end
    $finish;
  end

endmodule

### chip8_instruction_execute.f
hdl/chip8_pkg.sv
hdl/chip8_alu.sv
hdl/chip8_instruction_execute.sv
test/chip8_instruction_execute_test.sv
